@@ design/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ design/rlestc_pkg.sv @@
// Package for the run-length stream threshold counter.
// Holds widths, register indexes, parse phases and the double compare.
package rlestc_pkg;
  localparam int MaxUniqueDefault = 16;
  localparam int CfgAddrW = 4;
  localparam logic [0:0] RegThreshold = 1'b0;
  localparam logic [0:0] RegMode      = 1'b1;
  localparam logic [2:0] CmpGt = 3'd0;
  localparam logic [2:0] CmpGe = 3'd1;
  localparam logic [2:0] CmpLt = 3'd2;
  localparam logic [2:0] CmpLe = 3'd3;
  localparam logic [2:0] CmpEq = 3'd4;

  typedef enum logic [5:0] {
    PH_COUNT  = 6'b000001,
    PH_TABLE  = 6'b000010,
    PH_RUNS   = 6'b000100,
    PH_INDEX  = 6'b001000,
    PH_LENGTH = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
    logic unord;
  } fcmp_t;

  // IEEE double compare of raw patterns: NaN unordered, -0 equals +0.
  function automatic fcmp_t fcmp(input logic [63:0] a, input logic [63:0] b);
    fcmp_t r;
    logic a_nan, b_nan, both_zero, mag_lt, mag_eq;
    a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
    b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
    both_zero = (a[62:0] == '0) && (b[62:0] == '0);
    mag_lt = a[62:0] < b[62:0];
    mag_eq = a[62:0] == b[62:0];
    r = '0;
    if (a_nan || b_nan) begin
      r.unord = 1'b1;
    end else if (both_zero || (a == b)) begin
      r.eq = 1'b1;
    end else if (a[63] != b[63]) begin
      r.lt = a[63];
      r.gt = b[63];
    end else if (a[63] == 1'b0) begin
      r.lt = mag_lt;
      r.gt = !mag_lt && !mag_eq;
    end else begin
      r.gt = mag_lt;
      r.lt = !mag_lt && !mag_eq;
    end
    return r;
  endfunction

  function automatic logic cmp_hit(input fcmp_t c, input logic [2:0] mode);
    logic h;
    case (mode)
      CmpGt: h = c.gt;
      CmpGe: h = c.gt || c.eq;
      CmpLt: h = c.lt;
      CmpLe: h = c.lt || c.eq;
      CmpEq: h = c.eq;
      default: h = 1'b0;
    endcase
    return h;
  endfunction
endpackage

@@ design/rlestc_if.sv @@
// Stream channel interfaces for the run-length stream threshold counter.
// Depends on nothing; payload fields of input and result words.
interface rlestc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface rlestc_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] match_count;
  modport source (output valid, status, match_count, input ready);
  modport sink (input valid, status, match_count, output ready);
endinterface

@@ design/rle_stream_threshold_counter_unit.sv @@
// Top level of the run-length stream threshold counter.
// Depends on rlestc_pkg, rlestc_if.sv and assert_macros.svh.
//
// The block takes one encoded stream byte per word, one word a cycle, and
// returns one result word per stream: the summed length of the runs whose
// table value passes the configured IEEE compare against the threshold, or
// a format error. Table bytes are written into a 64-bit wide value memory
// with a registered read; each index varint issues a read, and the compare
// and add happen when the run length varint completes. At least one length
// byte follows an index, so the read data is always ready in time and the
// sustained rate is one byte per cycle. The result word appears in the output
// register, written when the byte that completes it is taken. The only stall is a
// result word held in the output register and not yet taken: input waits
// until that word is taken.
module rle_stream_threshold_counter_unit #(
  parameter int MAX_UNIQUE = rlestc_pkg::MaxUniqueDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [rlestc_pkg::CfgAddrW-1:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready,
  rlestc_in_if.sink   in_ch,
  rlestc_out_if.source out_ch
);
  import rlestc_pkg::*;
  `include "assert_macros.svh"

  localparam int IdxW = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
  localparam int PosW = IdxW + 3;

  logic [63:0] threshold_bits;
  logic [2:0]  compare_mode;
  phase_t      phase, phase_next;
  logic [7:0]  distinct_count;
  logic [PosW-1:0] byte_position;
  logic [31:0] runs_left;
  logic [31:0] varint_value;
  logic [2:0]  varint_bytes;
  logic [IdxW-1:0] current_index;
  logic [63:0] running_count;
  logic [63:0] table_mem [MAX_UNIQUE];
  logic [63:0] rd_data;
  logic [63:0] wr_word;
  logic [63:0] assembly;

  logic accept, cfg_wr;
  logic emit;
  logic emit_status;
  logic [63:0] emit_count;
  logic [31:0] vnew;
  logic [4:0]  vshift;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    case (paddr[3])
      RegThreshold: prdata = threshold_bits;
      RegMode:      prdata = {61'd0, compare_mode};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_bits <= '0;
      compare_mode <= CmpGt;
    end else if (cfg_wr && paddr[2:0] == 3'd0) begin
      case (paddr[3])
        RegThreshold: threshold_bits <= pwdata;
        RegMode:      compare_mode <= pwdata[2:0];
        default:      ;
      endcase
    end
  end

  // The output register parts the two sides: a held result only blocks input.
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  assign vshift = 5'(7 * varint_bytes);
  assign vnew = varint_value | (32'({in_ch.data_byte[6:0]}) << vshift);
  // Bytes of a table entry gather in a register; the memory is written
  // once per entry when its eighth byte arrives.
  assign wr_word = {in_ch.data_byte, assembly[63:8]};

  always_ff @(posedge clk) begin
    if (accept && phase == PH_TABLE && byte_position[2:0] == 3'd7) begin
      table_mem[byte_position[PosW-1:3]] <= wr_word;
    end
    if (accept && phase == PH_INDEX && !in_ch.data_byte[7]) begin
      rd_data <= table_mem[vnew[IdxW-1:0]];
    end
  end

  always_comb begin
    phase_next = phase;
    emit = 1'b0;
    emit_status = 1'b0;
    emit_count = '0;
    case (phase)
      PH_COUNT: begin
        if (in_ch.data_byte == 8'd0 || 32'(in_ch.data_byte) > 32'(MAX_UNIQUE)) begin
          emit = 1'b1;
          emit_status = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_TABLE;
        end
      end
      PH_TABLE: begin
        if (byte_position == PosW'({distinct_count, 3'd0} - 11'd1))
          phase_next = PH_RUNS;
      end
      PH_RUNS: begin
        if (byte_position[1:0] == 2'd3) begin
          if ({in_ch.data_byte, runs_left[31:8]} == 32'd0) begin
            emit = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_INDEX;
          end
        end
      end
      PH_INDEX, PH_LENGTH: begin
        if (in_ch.data_byte[7]) begin
          if (varint_bytes >= 3'd4) begin
            emit = 1'b1;
            emit_status = 1'b1;
            phase_next = PH_DONE;
          end
        end else if (phase == PH_INDEX) begin
          if (vnew >= 32'(distinct_count)) begin
            emit = 1'b1;
            emit_status = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_LENGTH;
          end
        end else if (runs_left == 32'd1) begin
          emit = 1'b1;
          emit_count = running_count +
            (cmp_hit(fcmp(rd_data, threshold_bits), compare_mode) ? 64'(vnew) : 64'd0);
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_INDEX;
        end
      end
      PH_DONE: ;
      default: phase_next = PH_COUNT;
    endcase
    if (in_ch.last_byte) begin
      if (!emit && phase != PH_DONE) begin
        emit = 1'b1;
        emit_status = 1'b1;
        emit_count = '0;
      end
      phase_next = PH_COUNT;
    end
    if (emit_status) emit_count = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_COUNT;
      distinct_count <= '0;
      byte_position <= '0;
      runs_left <= '0;
      varint_value <= '0;
      varint_bytes <= '0;
      current_index <= '0;
      running_count <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.ready) out_ch.valid <= 1'b0;
      if (accept) begin
        phase <= phase_next;
        if (emit) begin
          out_ch.valid <= 1'b1;
          out_ch.status <= emit_status;
          out_ch.match_count <= emit_count;
        end
        case (phase)
          PH_COUNT: begin
            distinct_count <= in_ch.data_byte;
            byte_position <= '0;
          end
          PH_TABLE: begin
            assembly <= wr_word;
            byte_position <= byte_position + 1'b1;
            if (phase_next == PH_RUNS) begin
              byte_position <= '0;
              runs_left <= '0;
            end
          end
          PH_RUNS: begin
            runs_left <= {in_ch.data_byte, runs_left[31:8]};
            byte_position <= byte_position + 1'b1;
            varint_value <= '0;
            varint_bytes <= '0;
          end
          PH_INDEX, PH_LENGTH: begin
            if (in_ch.data_byte[7]) begin
              varint_value <= vnew;
              varint_bytes <= varint_bytes + 1'b1;
            end else begin
              varint_value <= '0;
              varint_bytes <= '0;
              if (phase == PH_INDEX) begin
                current_index <= vnew[IdxW-1:0];
              end else begin
                runs_left <= runs_left - 1'b1;
                if (!cmp_hit(fcmp(rd_data, threshold_bits), compare_mode))
                  running_count <= running_count;
                else
                  running_count <= running_count + 64'(vnew);
              end
            end
          end
          default: ;
        endcase
        if (in_ch.last_byte) begin
          distinct_count <= '0;
          byte_position <= '0;
          runs_left <= '0;
          varint_value <= '0;
          varint_bytes <= '0;
          current_index <= '0;
          running_count <= '0;
        end
      end
    end
  end

  `ASSERT_CLK(a_no_drop, clk, rst, (out_ch.valid && !out_ch.ready) |=> out_ch.valid,
    "result word dropped while stalled")
  `ASSERT_CLK(a_err_zero, clk, rst,
    (out_ch.valid && out_ch.status) |-> (out_ch.match_count == 64'd0),
    "error result carries a nonzero count")
  `ASSERT_CLK(a_last_restart, clk, rst, (accept && in_ch.last_byte) |=> (phase == PH_COUNT),
    "parser did not restart after the final byte")
  `ASSERT_CLK(a_idx_range, clk, rst,
    (phase == PH_LENGTH) |-> (32'(current_index) < 32'(distinct_count)),
    "current index outside the table")
endmodule
